// ----- sv/lrf_pkg.sv -----
// ----------------------------------------------------------------------------
// lrf_pkg
// Shared codes, controller states and geometry constants of the line
// raster framebuffer.
// ----------------------------------------------------------------------------
package lrf_pkg;

    // command codes
    localparam logic [1:0] CMD_DRAW  = 2'd0;
    localparam logic [1:0] CMD_CLEAR = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;

    localparam logic [7:0] WIDTH_RESET  = 8'd128;
    localparam logic [6:0] HEIGHT_RESET = 7'd64;

    // page layout: eight rows per byte
    localparam int PAGE_SHIFT = 3;
    localparam int PAGE_ROUND = 7;

    typedef enum logic [7:0] {
        ST_INIT  = 8'b0000_0001,
        ST_IDLE  = 8'b0000_0010,
        ST_SETUP = 8'b0000_0100,
        ST_ORDER = 8'b0000_1000,
        ST_DRAW  = 8'b0001_0000,
        ST_DRAIN = 8'b0010_0000,
        ST_CLEAR = 8'b0100_0000,
        ST_READ  = 8'b1000_0000
    } state_t;

endpackage

// ----- sv/line_raster_framebuffer_top.sv -----
// ----------------------------------------------------------------------------
// line_raster_framebuffer_top
// Monochrome framebuffer in page layout (byte x + (y/8)*width, bit y mod 8)
// with a Bresenham line rasterizer, a clear command and a byte read port.
// An item is taken when start is high and busy is low; its single result
// shows on read_data / is_read_result for the one cycle in which done is
// high, and the receiver cannot stall it. After reset the block sweeps the
// store to zero, one byte a cycle (all MAX_COLUMNS * ceil(MAX_ROWS/8)
// bytes, 1024 at the defaults) with busy high; configuration writes are
// taken at any time. A draw runs the setup and ordering steps, then one
// pixel per cycle, max(|dx|, |dy|) + 1 pixels, through the store's
// read-modify-write, whether the pixel is on screen or clipped, and a drain
// step to retire the last write. A clear zeroes the used bytes through the
// single write port; a read answers from the registered read of the store.
// done rises in the same cycle as busy drops; an unknown command answers
// in the cycle after it is taken.
// ----------------------------------------------------------------------------
module line_raster_framebuffer_top #(
    parameter int MAX_COLUMNS = 128,
    parameter int MAX_ROWS    = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  command,
    input  logic signed [15:0] start_x,
    input  logic signed [15:0] start_y,
    input  logic signed [15:0] end_x,
    input  logic signed [15:0] end_y,
    input  logic [9:0]  read_index,
    output logic        done,
    output logic [7:0]  read_data,
    output logic        is_read_result
);

    import lrf_pkg::*;

    localparam int PAGES  = (MAX_ROWS + PAGE_ROUND) / 8;
    localparam int DEPTH  = MAX_COLUMNS * PAGES;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int UW     = $clog2(DEPTH + 1);
    localparam int CW     = $clog2(MAX_COLUMNS + 1);
    localparam int WW     = (CW > 8) ? CW : 8;
    localparam int RH     = $clog2(MAX_ROWS + 1);
    localparam int HW     = (RH > 7) ? RH : 7;
    localparam int COLB   = $clog2(MAX_COLUMNS);
    localparam int PI_W   = (PAGES > 1) ? $clog2(PAGES) : 1;
    localparam int CMPW   = (UW > 10) ? UW : 10;

    // control state
    state_t            state_reg, state_next;
    logic [7:0]        width_reg, width_next;
    logic [6:0]        height_reg, height_next;
    logic [UW-1:0]     clr_cnt_reg, clr_cnt_next;
    logic              pend_valid_reg, pend_valid_next;
    logic              wr_valid_reg;
    logic              done_reg, done_next;

    // payload
    logic signed [15:0] sx_reg, sy_reg, ex_reg, ey_reg;
    logic signed [15:0] maj0_reg, min0_reg, maj1_reg, min1_reg;
    logic               steep_reg, steep_next;
    logic signed [16:0] maj_reg, maj_next;
    logic signed [16:0] min_reg, min_next;
    logic signed [17:0] err_reg, err_next;
    logic [15:0]        dx_reg, dx_next;
    logic [15:0]        dy_reg, dy_next;
    logic [15:0]        cnt_reg, cnt_next;
    logic               step_up_reg, step_up_next;
    logic [ADDR_W-1:0]  pend_addr_reg;
    logic [7:0]         pend_mask_reg;
    logic [ADDR_W-1:0]  wr_addr_reg;
    logic [7:0]         wr_data_reg;
    logic               rd_ok_reg, rd_ok_next;
    logic [7:0]         read_data_reg, read_data_next;
    logic               is_read_reg, is_read_next;

    // geometry
    logic [WW-1:0]     eff_w;
    logic [HW-1:0]     eff_h;
    logic [HW:0]       h_round;
    logic [HW:0]       pages_used;
    logic [UW-1:0]     used;

    // memory ports
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [7:0]        ram_wdata;
    logic [ADDR_W-1:0] ram_raddr;
    logic [7:0]        ram_rdata;

    // setup / ordering
    logic signed [16:0] sdx, sdy, dmaj, dmin;
    logic [15:0]        adx, ady;
    logic               swap;
    logic signed [15:0] majlo, minlo, majhi, minhi;

    // pixel
    logic signed [16:0] px, py;
    logic               on_screen;
    logic [PI_W-1:0]    page;
    logic [UW-1:0]      pix_addr;
    logic [7:0]         pix_mask;
    logic signed [17:0] err_dec;
    logic               accept;
    logic               fwd;

    assign eff_w = (WW'(width_reg) > WW'(MAX_COLUMNS)) ? WW'(MAX_COLUMNS) : WW'(width_reg);
    assign eff_h = (HW'(height_reg) > HW'(MAX_ROWS)) ? HW'(MAX_ROWS) : HW'(height_reg);
    assign h_round    = (HW + 1)'(eff_h) + (HW + 1)'(PAGE_ROUND);
    assign pages_used = h_round >> PAGE_SHIFT;
    assign used       = UW'(eff_w * pages_used);

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;

    // endpoint magnitudes for the steep test
    assign sdx = 17'(ex_reg) - 17'(sx_reg);
    assign sdy = 17'(ey_reg) - 17'(sy_reg);
    assign adx = sdx[16] ? 16'(-sdx) : sdx[15:0];
    assign ady = sdy[16] ? 16'(-sdy) : sdy[15:0];

    // order endpoints by major coordinate
    assign swap  = (maj0_reg > maj1_reg);
    assign majlo = swap ? maj1_reg : maj0_reg;
    assign minlo = swap ? min1_reg : min0_reg;
    assign majhi = swap ? maj0_reg : maj1_reg;
    assign minhi = swap ? min0_reg : min1_reg;
    assign dmaj  = 17'(majhi) - 17'(majlo);
    assign dmin  = 17'(minhi) - 17'(minlo);

    // current pixel and its byte address
    assign px = steep_reg ? min_reg : maj_reg;
    assign py = steep_reg ? maj_reg : min_reg;
    assign on_screen = !px[16] && (px[15:0] < 16'(eff_w))
                    && !py[16] && (py[15:0] < 16'(eff_h));
    assign page     = PI_W'(py[16:PAGE_SHIFT]);
    assign pix_addr = UW'(px[COLB-1:0]) + UW'(page * eff_w);
    assign pix_mask = 8'd1 << py[2:0];

    assign err_dec = err_reg - $signed({2'b00, dy_reg});

    // a write retired last cycle is not yet seen by the registered read
    assign fwd = wr_valid_reg && (wr_addr_reg == pend_addr_reg);

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = pend_addr_reg;
        ram_wdata = (fwd ? wr_data_reg : ram_rdata) | pend_mask_reg;
        if (pend_valid_reg)
        begin
            ram_we = 1'b1;
        end
        else if ((state_reg == ST_INIT)
                 || ((state_reg == ST_CLEAR) && (clr_cnt_reg != used)))
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_cnt_reg[ADDR_W-1:0];
            ram_wdata = '0;
        end
        ram_raddr = (state_reg == ST_DRAW) ? pix_addr[ADDR_W-1:0] : ADDR_W'(read_index);
    end

    always_comb
    begin
        state_next      = state_reg;
        width_next      = width_reg;
        height_next     = height_reg;
        clr_cnt_next    = clr_cnt_reg;
        pend_valid_next = 1'b0;
        done_next       = 1'b0;
        read_data_next  = '0;
        is_read_next    = 1'b0;
        steep_next      = steep_reg;
        maj_next        = maj_reg;
        min_next        = min_reg;
        err_next        = err_reg;
        dx_next         = dx_reg;
        dy_next         = dy_reg;
        cnt_next        = cnt_reg;
        step_up_next    = step_up_reg;
        rd_ok_next      = rd_ok_reg;

        if (cfg_write)
        begin
            case (cfg_index)
                REG_WIDTH:  width_next  = cfg_data;
                REG_HEIGHT: height_next = cfg_data[6:0];
                default:    ;
            endcase
        end

        case (state_reg)
            ST_INIT:
            begin
                clr_cnt_next = clr_cnt_reg + UW'(1);
                if (clr_cnt_reg == UW'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (command)
                        CMD_DRAW:  state_next = ST_SETUP;
                        CMD_CLEAR:
                        begin
                            clr_cnt_next = '0;
                            state_next   = ST_CLEAR;
                        end
                        CMD_READ:
                        begin
                            rd_ok_next = (CMPW'(read_index) < CMPW'(used));
                            state_next = ST_READ;
                        end
                        default:   done_next = 1'b1;
                    endcase
                end
            end
            ST_SETUP:
            begin
                steep_next = (ady > adx);
                state_next = ST_ORDER;
            end
            ST_ORDER:
            begin
                maj_next     = 17'(majlo);
                min_next     = 17'(minlo);
                dx_next      = dmaj[15:0];
                dy_next      = dmin[16] ? 16'(-dmin) : dmin[15:0];
                cnt_next     = dmaj[15:0];
                err_next     = 18'(dmaj[15:1]);
                step_up_next = !dmin[16] && (dmin != '0);
                state_next   = ST_DRAW;
            end
            ST_DRAW:
            begin
                pend_valid_next = on_screen;
                maj_next = maj_reg + 17'sd1;
                cnt_next = cnt_reg - 16'd1;
                if (err_dec[17])
                begin
                    err_next = err_dec + $signed({2'b00, dx_reg});
                    min_next = step_up_reg ? (min_reg + 17'sd1) : (min_reg - 17'sd1);
                end
                else
                begin
                    err_next = err_dec;
                end
                if (cnt_reg == '0)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end
            ST_CLEAR:
            begin
                if (clr_cnt_reg == used)
                begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + UW'(1);
                end
            end
            ST_READ:
            begin
                done_next      = 1'b1;
                is_read_next   = 1'b1;
                read_data_next = rd_ok_reg ? ram_rdata : 8'd0;
                state_next     = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_INIT;
            width_reg      <= WIDTH_RESET;
            height_reg     <= HEIGHT_RESET;
            clr_cnt_reg    <= '0;
            pend_valid_reg <= 1'b0;
            wr_valid_reg   <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            width_reg      <= width_next;
            height_reg     <= height_next;
            clr_cnt_reg    <= clr_cnt_next;
            pend_valid_reg <= pend_valid_next;
            wr_valid_reg   <= ram_we;
            done_reg       <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sx_reg <= start_x;
            sy_reg <= start_y;
            ex_reg <= end_x;
            ey_reg <= end_y;
        end
        if (state_reg == ST_SETUP)
        begin
            maj0_reg <= (ady > adx) ? sy_reg : sx_reg;
            min0_reg <= (ady > adx) ? sx_reg : sy_reg;
            maj1_reg <= (ady > adx) ? ey_reg : ex_reg;
            min1_reg <= (ady > adx) ? ex_reg : ey_reg;
        end
        steep_reg     <= steep_next;
        maj_reg       <= maj_next;
        min_reg       <= min_next;
        err_reg       <= err_next;
        dx_reg        <= dx_next;
        dy_reg        <= dy_next;
        cnt_reg       <= cnt_next;
        step_up_reg   <= step_up_next;
        rd_ok_reg     <= rd_ok_next;
        pend_addr_reg <= pix_addr[ADDR_W-1:0];
        pend_mask_reg <= pix_mask;
        wr_addr_reg   <= ram_waddr;
        wr_data_reg   <= ram_wdata;
        read_data_reg <= read_data_next;
        is_read_reg   <= is_read_next;
    end

    lrf_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_frame_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign done           = done_reg;
    assign read_data      = read_data_reg;
    assign is_read_result = is_read_reg;

    // the store is quiet whenever the block is idle
    a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !ram_we)
        else $error("store written while idle");

    // no pixel write may still be in flight when a new item is taken
    a_accept_drained: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> !pend_valid_reg)
        else $error("item taken with a pixel write pending");

    // pixel writes only come out of the draw loop
    a_pend_in_draw: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> ((state_reg == ST_DRAW) || (state_reg == ST_DRAIN)))
        else $error("pixel write outside a draw");

    // a read answers in the following cycle, marked as a read
    a_read_answers: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ) |=> (done && is_read_result))
        else $error("read result missing");

endmodule

// ----- sv/lrf_ram.sv -----
// ----------------------------------------------------------------------------
// lrf_ram
// Simple dual-port synchronous RAM: one write port, one read port with
// registered read data (old data on a same-address write).
// ----------------------------------------------------------------------------
module lrf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- verif/line_raster_framebuffer_top_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// line_raster_framebuffer_top_test
// Self-checking bench for the line raster framebuffer. A queue of draw,
// clear, read and unused commands feeds a clocked driver with random start
// gaps; every taken item is applied to a local copy of the frame store and
// geometry, and the answer it gives is matched against the next done strobe.
// The run steps through several screen geometries, the extremes among them.
// ----------------------------------------------------------------------------
module line_raster_framebuffer_top_test;
    import lrf_pkg::*;

    localparam int COLUMNS     = 128;
    localparam int ROWS        = 64;
    localparam int STORE_SIZE  = COLUMNS * ((ROWS + PAGE_ROUND) >> PAGE_SHIFT);
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 175;
    localparam int IDLE_PCT    = 34;

    localparam logic [1:0] CMD_UNUSED  = 2'd3;
    localparam logic [1:0] REG_SPARE_A = 2'd2;
    localparam logic [1:0] REG_SPARE_B = 2'd3;

    typedef struct {
        logic [1:0]         code;
        logic signed [15:0] x0;
        logic signed [15:0] y0;
        logic signed [15:0] x1;
        logic signed [15:0] y1;
        logic [9:0]         index;
    } fb_item_t;

    typedef struct {
        logic [7:0] data;
        logic       is_read;
    } fb_answer_t;

    logic               clk            = 1'b0;
    logic               rst_n          = 1'b0;
    logic               cfg_write      = 1'b0;
    logic [1:0]         cfg_index      = REG_WIDTH;
    logic [7:0]         cfg_data       = '0;
    logic               start          = 1'b0;
    logic               busy;
    logic [1:0]         command        = CMD_DRAW;
    logic signed [15:0] start_x        = '0;
    logic signed [15:0] start_y        = '0;
    logic signed [15:0] end_x          = '0;
    logic signed [15:0] end_y          = '0;
    logic [9:0]         read_index     = '0;
    logic               done;
    logic [7:0]         read_data;
    logic               is_read_result;

    // local copy of the store and geometry
    logic [7:0] pixel_bytes [STORE_SIZE];
    logic [7:0] cols_reg;
    logic [6:0] rows_reg;

    fb_item_t   queued_items[$];
    fb_answer_t awaited_answers[$];
    fb_item_t   current;
    bit         loaded = 1'b0;
    int         accepted = 0;
    int         error_count = 0;
    longint     cycle_count = 0;
    longint     time_budget = 0;

    line_raster_framebuffer_top #(
        .MAX_COLUMNS(COLUMNS),
        .MAX_ROWS   (ROWS)
    ) uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .start         (start),
        .busy          (busy),
        .command       (command),
        .start_x       (start_x),
        .start_y       (start_y),
        .end_x         (end_x),
        .end_y         (end_y),
        .read_index    (read_index),
        .done          (done),
        .read_data     (read_data),
        .is_read_result(is_read_result)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic int used_cols();
        return (cols_reg > COLUMNS) ? COLUMNS : int'(cols_reg);
    endfunction

    function automatic int used_rows();
        return (rows_reg > ROWS) ? ROWS : int'(rows_reg);
    endfunction

    function automatic int used_size();
        return used_cols() * ((used_rows() + PAGE_ROUND) >> PAGE_SHIFT);
    endfunction

    function automatic int magnitude(int v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic int span(int lo, int hi);
        return lo + int'($urandom_range(hi - lo, 0));
    endfunction

    function automatic int clip16(int v);
        return (v > 32767) ? 32767 : ((v < -32768) ? -32768 : v);
    endfunction

    function automatic void set_pixel(int x, int y);
        int idx;
        if (x < 0 || x >= used_cols() || y < 0 || y >= used_rows())
            return;
        idx = x + (y >> PAGE_SHIFT) * used_cols();
        if (idx < STORE_SIZE)
            pixel_bytes[idx][y & PAGE_ROUND] = 1'b1;
    endfunction

    function automatic void raster_segment(int ax, int ay, int bx, int by);
        bit steep;
        int t;
        int dx;
        int dy;
        int err;
        int step_dir;
        steep = magnitude(by - ay) > magnitude(bx - ax);
        if (steep)
        begin
            t = ax; ax = ay; ay = t;
            t = bx; bx = by; by = t;
        end
        if (ax > bx)
        begin
            t = ax; ax = bx; bx = t;
            t = ay; ay = by; by = t;
        end
        dx = bx - ax;
        dy = magnitude(by - ay);
        err = dx / 2;
        step_dir = (ay < by) ? 1 : -1;
        while (ax <= bx)
        begin
            if (steep)
                set_pixel(ay, ax);
            else
                set_pixel(ax, ay);
            err -= dy;
            if (err < 0)
            begin
                ay += step_dir;
                err += dx;
            end
            ax++;
        end
    endfunction

    function automatic fb_answer_t apply_item(fb_item_t it);
        fb_answer_t ans;
        ans.data = '0;
        ans.is_read = 1'b0;
        case (it.code)
            CMD_DRAW:
                raster_segment(it.x0, it.y0, it.x1, it.y1);
            CMD_CLEAR:
                for (int i = 0; i < used_size() && i < STORE_SIZE; i++)
                    pixel_bytes[i] = '0;
            CMD_READ:
            begin
                ans.is_read = 1'b1;
                if (it.index < used_size())
                    ans.data = pixel_bytes[it.index];
            end
            default:
                ;
        endcase
        return ans;
    endfunction

    // slowest cycles the block may spend on one item
    function automatic int item_cycles(fb_item_t it);
        int ddx;
        int ddy;
        ddx = magnitude(int'(it.x1) - int'(it.x0));
        ddy = magnitude(int'(it.y1) - int'(it.y0));
        case (it.code)
            CMD_DRAW:  return ((ddx > ddy) ? ddx : ddy) + 4;
            CMD_CLEAR: return used_size() + 1;
            CMD_READ:  return 2;
            default:   return 1;
        endcase
    endfunction

    function automatic fb_item_t random_item();
        fb_item_t it;
        int pick;
        int cls;
        int w;
        int h;
        w = used_cols();
        h = used_rows();
        it.code  = CMD_DRAW;
        it.x0    = 16'($urandom);
        it.y0    = 16'($urandom);
        it.x1    = 16'($urandom);
        it.y1    = 16'($urandom);
        it.index = 10'($urandom);
        pick = $urandom_range(99);
        if (pick < 52)
        begin
            cls = $urandom_range(199);
            if (cls >= 1 && cls < 140)
            begin
                it.x0 = 16'(span(-16, w + 15));
                it.y0 = 16'(span(-16, h + 15));
                it.x1 = 16'(span(-16, w + 15));
                it.y1 = 16'(span(-16, h + 15));
            end
            else if (cls >= 140 && cls < 180)
            begin
                // far away but short
                it.x1 = 16'(clip16(it.x0 + span(-6, 6)));
                it.y1 = 16'(clip16(it.y0 + span(-6, 6)));
            end
            else if (cls >= 180)
            begin
                it.x0 = 16'(span(-16, w + 15));
                it.y0 = 16'(span(-16, h + 15));
                it.x1 = 16'(clip16(it.x0 + span(-700, 700)));
                it.y1 = 16'(clip16(it.y0 + span(-700, 700)));
            end
        end
        else if (pick < 92)
        begin
            it.code = CMD_READ;
            if (used_size() > 0 && $urandom_range(4) != 0)
                it.index = 10'($urandom_range(used_size() - 1));
        end
        else if (pick < 96)
            it.code = CMD_CLEAR;
        else
            it.code = CMD_UNUSED;
        return it;
    endfunction

    task automatic push_item(fb_item_t it);
        queued_items.push_back(it);
        time_budget += item_cycles(it) + 24;
    endtask

    task automatic push_cmd(logic [1:0] code, int x0, int y0, int x1, int y1, int index);
        fb_item_t it;
        it.code  = code;
        it.x0    = 16'(x0);
        it.y0    = 16'(y0);
        it.x1    = 16'(x1);
        it.y1    = 16'(y1);
        it.index = 10'(index);
        push_item(it);
    endtask

    task automatic write_register(logic [1:0] idx, logic [7:0] value);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        if (idx == REG_WIDTH)
            cols_reg = value;
        else if (idx == REG_HEIGHT)
            rows_reg = value[6:0];
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (queued_items.size() != 0 || loaded || awaited_answers.size() != 0 || busy);
        repeat (8) @(negedge clk);
    endtask

    task automatic report_mismatch(string what);
        error_count++;
        $display("mismatch at cycle %0d: %s", cycle_count, what);
    endtask

    // driver: one item held until taken, start dropped at random
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            loaded = 1'b0;
        end
        else
        begin
            if (start && !busy)
            begin
                awaited_answers.push_back(apply_item(current));
                loaded = 1'b0;
                accepted++;
            end
            if (!loaded && queued_items.size() != 0)
            begin
                current = queued_items.pop_front();
                loaded = 1'b1;
                command    <= current.code;
                start_x    <= current.x0;
                start_y    <= current.y0;
                end_x      <= current.x1;
                end_y      <= current.y1;
                read_index <= current.index;
            end
            // a stretch of items with no gaps at all
            start <= loaded && ((accepted >= 500 && accepted < 750)
                                || $urandom_range(99) >= IDLE_PCT);
        end
    end

    always @(posedge clk)
    begin : monitor
        fb_answer_t want;
        if (rst_n)
        begin
            cycle_count++;
            if (done)
            begin
                if (awaited_answers.size() == 0)
                    report_mismatch("done with no item outstanding");
                else
                begin
                    want = awaited_answers.pop_front();
                    if (read_data !== want.data)
                        report_mismatch($sformatf("read_data %h, expected %h",
                                                  read_data, want.data));
                    if (is_read_result !== want.is_read)
                        report_mismatch($sformatf("is_read_result %b, expected %b",
                                                  is_read_result, want.is_read));
                end
            end
        end
    end

    initial
    begin : watchdog
        do
            @(posedge clk);
        while (cycle_count <= 4 * time_budget + 20000);
        $display("line_raster_framebuffer_top regression: fail");
        $finish;
    end

    initial
    begin : stimulus
        int w;
        int h;
        foreach (pixel_bytes[i])
            pixel_bytes[i] = '0;
        cols_reg = WIDTH_RESET;
        rows_reg = HEIGHT_RESET;
        time_budget = STORE_SIZE + 64;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        wait_idle();

        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0:       begin w = 128; h = 64; end
                1:       begin w = 1; h = 1; end
                2:       begin w = 255; h = 255; end
                3:       begin w = 0; h = 64; end
                4:       begin w = 37; h = 0; end
                5:       begin w = span(1, 128); h = span(1, 64); end
                6:       begin w = 128; h = 13; end
                default: begin w = $urandom_range(255); h = $urandom_range(255); end
            endcase
            write_register(REG_WIDTH, 8'(w));
            write_register(REG_HEIGHT, 8'(h));
            if (p == 0)
            begin
                // writes to unused indexes must not move the geometry
                write_register(REG_SPARE_A, 8'h05);
                write_register(REG_SPARE_B, 8'hFF);
                push_cmd(CMD_READ, -1, 32767, -32768, 0, 0);
                push_cmd(CMD_READ, 0, 0, 0, 0, 1023);
                push_cmd(CMD_DRAW, 0, 0, 127, 0, 1023);
                push_cmd(CMD_READ, 5, 5, 5, 5, 127);
                push_cmd(CMD_DRAW, 5, -3, 5, 70, $urandom_range(1023));
                push_cmd(CMD_READ, 0, 0, 0, 0, 5 + 7 * 128);
                push_cmd(CMD_DRAW, 100, 63, 90, 0, 0);
                push_cmd(CMD_DRAW, 127, 63, 127, 63, 0);
                push_cmd(CMD_DRAW, -10, -10, -1, -5, 0);
                push_cmd(CMD_READ, 0, 0, 0, 0, 127 + 7 * 128);
                // full-span endpoints, no 16-bit wrap of the differences
                push_cmd(CMD_DRAW, -32768, -32768, 32767, 32767, 0);
                push_cmd(CMD_DRAW, 32767, 10, -32768, 10, 0);
                push_cmd(CMD_DRAW, 3, 32767, 3, -32768, 0);
                push_cmd(CMD_DRAW, 32767, 32767, 32767, 32767, 0);
                push_cmd(CMD_DRAW, -32768, -32768, -32768, -32768, 0);
                push_cmd(CMD_READ, 0, 0, 0, 0, 10 + 128);
                push_cmd(CMD_READ, 0, 0, 0, 0, 3 + 3 * 128);
                push_cmd(CMD_UNUSED, -32768, 32767, 12, -7, 1023);
                push_cmd(CMD_READ, -32768, -32768, 32767, 32767, 300);
                push_cmd(CMD_CLEAR, 40, 40, 1, 1, 1023);
                push_cmd(CMD_READ, 0, 0, 0, 0, 0);
                push_cmd(CMD_READ, 0, 0, 0, 0, 5 + 7 * 128);
                push_cmd(CMD_DRAW, 0, 63, 127, 0, 0);
                push_cmd(CMD_READ, 0, 0, 0, 0, 64 + 3 * 128);
            end
            for (int n = 0; n < PHASE_ITEMS; n++)
                push_item(random_item());
            wait_idle();
        end

        if (error_count == 0 && awaited_answers.size() == 0)
            $display("line_raster_framebuffer_top regression: pass");
        else
            $display("line_raster_framebuffer_top regression: fail");
        $finish;
    end

endmodule
